### hdl/cubic_bezier_point_eval_assert.svh
// Assertion macros used by the curve evaluator RTL.
`ifndef CUBIC_BEZIER_POINT_EVAL_ASSERT_SVH
`define CUBIC_BEZIER_POINT_EVAL_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define CBPE_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CBPE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/cbpe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cbpe_pkg;

   // Width of one multiplier operand slice in the interpolation stages.
   localparam int LIMB_BITS = 32;

   // x and y are evaluated side by side.
   localparam int NUM_AXES = 2;

   // Load enables for the three register stages of one interpolation unit.
   typedef struct packed {
      logic cap;
      logic mul;
      logic sum;
   } lerp_en_type;

endpackage

`default_nettype wire

### hdl/cbpe_lerp.sv
`timescale 1ns / 1ps
`default_nettype none

// Exact linear interpolation a*(1-t) + b*t, scaled by 2^FRAC, as
// a*2^FRAC + (b-a)*t. Three register stages: difference, sliced
// multiply, recombine. The result is convex in a and b, so it fits
// IN_W+FRAC bits and the sum is formed modulo that width.
module cbpe_lerp #(
   parameter int IN_W = 16,
   parameter int FRAC = 16
) (
   input  logic                          clock,
   input  cbpe_pkg::lerp_en_type         en,
   input  logic signed [IN_W-1:0]        a,
   input  logic signed [IN_W-1:0]        b,
   input  logic        [FRAC:0]          t,
   output logic signed [IN_W+FRAC-1:0]   lerp_out
);
   import cbpe_pkg::*;

   localparam int DW  = IN_W + 1;
   localparam int NL  = (DW + LIMB_BITS - 1) / LIMB_BITS;
   localparam int DXW = NL * LIMB_BITS;
   localparam int PW  = LIMB_BITS + FRAC + 3;
   localparam int OW  = IN_W + FRAC;

   logic signed [IN_W-1:0] a_ff;
   logic signed [IN_W-1:0] a2_ff;
   logic signed [DW-1:0]   d_ff;
   logic signed [DXW-1:0]  d_ext;
   logic signed [FRAC+1:0] t_s;
   logic signed [PW-1:0]   pp_in [NL];
   logic signed [PW-1:0]   pp_ff [NL];
   logic signed [OW-1:0]   sum_in;
   logic signed [OW-1:0]   lerp_ff;

   assign d_ext = DXW'(d_ff);
   assign t_s   = $signed({1'b0, t});

   // Slice the difference: low slices unsigned, top slice carries the sign
   for (genvar gi = 0; gi < NL; gi++) begin : g_limb
      logic signed [LIMB_BITS:0] limb;
      if (gi == NL - 1) begin : g_top
         assign limb = $signed({d_ext[DXW-1], d_ext[gi*LIMB_BITS +: LIMB_BITS]});
      end else begin : g_low
         assign limb = $signed({1'b0, d_ext[gi*LIMB_BITS +: LIMB_BITS]});
      end
      assign pp_in[gi] = limb * t_s;
   end

   // Recombine the slice products with the scaled base point
   always_comb begin
      sum_in = OW'(a2_ff) <<< FRAC;
      for (int i = 0; i < NL; i++) begin
         sum_in = sum_in + (OW'(pp_ff[i]) <<< (LIMB_BITS * i));
      end
   end

   // Advance each stage on its own enable
   always_ff @(posedge clock) begin
      if (en.cap) begin
         a_ff <= a;
         d_ff <= DW'(b) - DW'(a);
      end
      if (en.mul) begin
         a2_ff <= a_ff;
         pp_ff <= pp_in;
      end
      if (en.sum) begin
         lerp_ff <= sum_in;
      end
   end

   assign lerp_out = lerp_ff;

endmodule

`default_nettype wire

### hdl/cubic_bezier_point_eval.sv
`timescale 1ns / 1ps
`default_nettype none
`include "cubic_bezier_point_eval_assert.svh"

// Cubic Bezier point evaluator, 2D. Each req beat carries t (unsigned
// Q1.T_FRAC_BITS, a value above 1.0 counts as 1.0) and four control points;
// each rsp beat returns the curve point, rounded to nearest with ties toward
// plus infinity and clamped to the coordinate range. The block takes one beat
// per clock while req_stall is low and returns results in order. Its stages
// come from the evaluation scheme: three levels of exact interpolation (de
// Casteljau), each three register stages deep (difference, multiply cut into
// 32-bit slices, recombine), plus an input register and a rounding/output
// register. Under rsp_stall the pipeline closes up its empty stages and keeps
// taking beats until every stage is full.
module cubic_bezier_point_eval #(
   parameter int COORD_BITS  = 16,
   parameter int T_FRAC_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic        [T_FRAC_BITS:0]  req_param_t,
   input  logic signed [COORD_BITS-1:0] req_p0_x,
   input  logic signed [COORD_BITS-1:0] req_p0_y,
   input  logic signed [COORD_BITS-1:0] req_p1_x,
   input  logic signed [COORD_BITS-1:0] req_p1_y,
   input  logic signed [COORD_BITS-1:0] req_p2_x,
   input  logic signed [COORD_BITS-1:0] req_p2_y,
   input  logic signed [COORD_BITS-1:0] req_p3_x,
   input  logic signed [COORD_BITS-1:0] req_p3_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_curve_x,
   output logic signed [COORD_BITS-1:0] rsp_curve_y
);
   import cbpe_pkg::*;

   localparam int C     = COORD_BITS;
   localparam int F     = T_FRAC_BITS;
   localparam int TW    = F + 1;
   localparam int W1    = C + F;
   localparam int W2    = C + 2 * F;
   localparam int W3    = C + 3 * F;
   localparam int RW    = W3 + 1;
   localparam int NSTG  = 11;
   localparam int LAST  = NSTG - 1;
   localparam int T_STG = 8;
   localparam int MID   = 5;
   localparam logic [TW-1:0]        T_ONE = {1'b1, {F{1'b0}}};
   localparam logic signed [RW-1:0] HALF  = RW'(1) <<< (3 * F - 1);
   localparam logic signed [C-1:0]  C_MAX = {1'b0, {(C-1){1'b1}}};
   localparam logic signed [C-1:0]  C_MIN = {1'b1, {(C-1){1'b0}}};

   logic [NSTG-1:0]        v_ff;
   logic [NSTG-1:0]        en;
   logic [TW-1:0]          t_ff  [T_STG];
   logic signed [C-1:0]    p_ff  [NUM_AXES][4];
   logic signed [W1-1:0]   lvl1  [NUM_AXES][3];
   logic signed [W2-1:0]   lvl2  [NUM_AXES][2];
   logic signed [W3-1:0]   lvl3  [NUM_AXES];
   logic signed [C-1:0]    curve_in [NUM_AXES];
   logic signed [C-1:0]    curve_ff [NUM_AXES];
   lerp_en_type            en_l1, en_l2, en_l3;

   // Stage loads when empty or when the stage after it moves
   always_comb begin
      en[LAST] = ~v_ff[LAST] | ~rsp_stall;
      for (int k = LAST - 1; k >= 0; k--) begin
         en[k] = ~v_ff[k] | en[k+1];
      end
   end

   assign req_stall = ~en[0];
   assign rsp_valid = v_ff[LAST];

   // Valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= req_valid;
         for (int k = 1; k < NSTG; k++) begin
            if (en[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   // Capture the beat; clamp t to 1.0
   always_ff @(posedge clock) begin
      if (en[0]) begin
         t_ff[0]    <= req_param_t[TW-1] ? T_ONE : req_param_t;
         p_ff[0][0] <= req_p0_x;
         p_ff[1][0] <= req_p0_y;
         p_ff[0][1] <= req_p1_x;
         p_ff[1][1] <= req_p1_y;
         p_ff[0][2] <= req_p2_x;
         p_ff[1][2] <= req_p2_y;
         p_ff[0][3] <= req_p3_x;
         p_ff[1][3] <= req_p3_y;
      end
      for (int k = 1; k < T_STG; k++) begin
         if (en[k]) t_ff[k] <= t_ff[k-1];
      end
   end

   assign en_l1 = '{cap: en[1], mul: en[2], sum: en[3]};
   assign en_l2 = '{cap: en[4], mul: en[5], sum: en[6]};
   assign en_l3 = '{cap: en[7], mul: en[8], sum: en[9]};

   // Three interpolation levels per axis
   for (genvar ax = 0; ax < NUM_AXES; ax++) begin : g_axis
      for (genvar j = 0; j < 3; j++) begin : g_l1
         cbpe_lerp #(.IN_W(C), .FRAC(F)) u_lerp (
            .clock    (clock),
            .en       (en_l1),
            .a        (p_ff[ax][j]),
            .b        (p_ff[ax][j+1]),
            .t        (t_ff[1]),
            .lerp_out (lvl1[ax][j])
         );
      end
      for (genvar j = 0; j < 2; j++) begin : g_l2
         cbpe_lerp #(.IN_W(W1), .FRAC(F)) u_lerp (
            .clock    (clock),
            .en       (en_l2),
            .a        (lvl1[ax][j]),
            .b        (lvl1[ax][j+1]),
            .t        (t_ff[4]),
            .lerp_out (lvl2[ax][j])
         );
      end
      cbpe_lerp #(.IN_W(W2), .FRAC(F)) u_l3 (
         .clock    (clock),
         .en       (en_l3),
         .a        (lvl2[ax][0]),
         .b        (lvl2[ax][1]),
         .t        (t_ff[7]),
         .lerp_out (lvl3[ax])
      );

      // Round half up, drop the fraction, clamp to the coordinate range
      logic signed [RW-1:0] rnd;
      logic signed [C:0]    q;
      assign rnd = RW'(lvl3[ax]) + HALF;
      assign q   = (C+1)'(rnd >>> (3 * F));
      always_comb begin
         if (q[C] != q[C-1]) begin
            curve_in[ax] = q[C] ? C_MIN : C_MAX;
         end else begin
            curve_in[ax] = q[C-1:0];
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (en[LAST]) curve_ff <= curve_in;
   end

   assign rsp_curve_x = curve_ff[0];
   assign rsp_curve_y = curve_ff[1];

   `CBPE_ASSERT_HOLDS(a_stall_only_full, clock, reset, req_stall,
      (v_ff == '1) && rsp_stall, "input stalled while a stage is free")
   `CBPE_ASSERT_NEXT(a_mid_hold, clock, reset, v_ff[MID] && !en[MID], v_ff[MID],
      "held middle stage lost its beat")
   `CBPE_ASSERT_NEXT(a_drain, clock, reset, en[LAST] && v_ff[LAST-1], rsp_valid,
      "beat did not reach the output register")
   `CBPE_ASSERT_HOLDS(a_t_clamped, clock, reset, v_ff[0], t_ff[0] <= T_ONE,
      "captured t above one")

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int COORD_BITS  = 16;
   localparam int T_FRAC_BITS = 16;
   localparam int RANDOM_BEATS = 1200;
   // Beats presented per idling phase.
   localparam int PHASE_LEN = 240;
   // Cycles the receiver holds off during the long hold-off.
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int DRAIN_CYCLES = 30;

   localparam logic signed [127:0] T_ONE = 128'sd1 <<< T_FRAC_BITS;
   localparam logic signed [127:0] ROUND_HALF = 128'sd1 <<< (3 * T_FRAC_BITS - 1);
   localparam logic signed [127:0] COORD_MAX = (128'sd1 <<< (COORD_BITS - 1)) - 1;
   localparam logic signed [127:0] COORD_MIN = -(128'sd1 <<< (COORD_BITS - 1));
   localparam logic signed [COORD_BITS-1:0] C_MAX = COORD_MAX[COORD_BITS-1:0];
   localparam logic signed [COORD_BITS-1:0] C_MIN = COORD_MIN[COORD_BITS-1:0];
   localparam logic [T_FRAC_BITS:0] T_ONE_Q = T_ONE[T_FRAC_BITS:0];
   localparam logic [T_FRAC_BITS:0] T_HALF_Q = T_ONE_Q >> 1;
   localparam logic [T_FRAC_BITS:0] T_TOP_Q = '1;

   typedef struct packed {
      logic        [T_FRAC_BITS:0]  param_t;
      logic signed [COORD_BITS-1:0] p0_x;
      logic signed [COORD_BITS-1:0] p0_y;
      logic signed [COORD_BITS-1:0] p1_x;
      logic signed [COORD_BITS-1:0] p1_y;
      logic signed [COORD_BITS-1:0] p2_x;
      logic signed [COORD_BITS-1:0] p2_y;
      logic signed [COORD_BITS-1:0] p3_x;
      logic signed [COORD_BITS-1:0] p3_y;
   } segment_beat_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] curve_x;
      logic signed [COORD_BITS-1:0] curve_y;
   } curve_point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic        [T_FRAC_BITS:0]  req_param_t = '0;
   logic signed [COORD_BITS-1:0] req_p0_x = '0;
   logic signed [COORD_BITS-1:0] req_p0_y = '0;
   logic signed [COORD_BITS-1:0] req_p1_x = '0;
   logic signed [COORD_BITS-1:0] req_p1_y = '0;
   logic signed [COORD_BITS-1:0] req_p2_x = '0;
   logic signed [COORD_BITS-1:0] req_p2_y = '0;
   logic signed [COORD_BITS-1:0] req_p3_x = '0;
   logic signed [COORD_BITS-1:0] req_p3_y = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic signed [COORD_BITS-1:0] rsp_curve_x;
   logic signed [COORD_BITS-1:0] rsp_curve_y;

   segment_beat_type segments_pending[$];
   curve_point_type  points_due[$];
   segment_beat_type next_segment;
   curve_point_type  due_point;

   logic req_fired = 1'b0;
   logic hold_off  = 1'b0;
   int   beats_sent = 0;
   int   beats_taken = 0;
   int   total_beats = 0;
   int   mismatches = 0;
   int   idle_pct;
   int   stall_pct;

   cubic_bezier_point_eval #(
      .COORD_BITS  (COORD_BITS),
      .T_FRAC_BITS (T_FRAC_BITS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_param_t (req_param_t),
      .req_p0_x    (req_p0_x),
      .req_p0_y    (req_p0_y),
      .req_p1_x    (req_p1_x),
      .req_p1_y    (req_p1_y),
      .req_p2_x    (req_p2_x),
      .req_p2_y    (req_p2_y),
      .req_p3_x    (req_p3_x),
      .req_p3_y    (req_p3_y),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_curve_x (rsp_curve_x),
      .rsp_curve_y (rsp_curve_y)
   );

   always #10 clock = ~clock;

   // Bernstein blend of one axis, summed exactly, rounded half up, clamped.
   function automatic logic signed [COORD_BITS-1:0] bernstein_axis(
      input logic        [T_FRAC_BITS:0]  t_raw,
      input logic signed [COORD_BITS-1:0] c0,
      input logic signed [COORD_BITS-1:0] c1,
      input logic signed [COORD_BITS-1:0] c2,
      input logic signed [COORD_BITS-1:0] c3
   );
      logic signed [127:0] t;
      logic signed [127:0] u;
      logic signed [127:0] w0, w1, w2, w3;
      logic signed [127:0] acc;
      t = t_raw;
      // saturate t to 1.0
      if (t > T_ONE) t = T_ONE;
      u = T_ONE - t;
      w0 = c0;
      w1 = c1;
      w2 = c2;
      w3 = c3;
      acc = u * u * u * w0 + 3 * t * u * u * w1 + 3 * t * t * u * w2 + t * t * t * w3;
      acc = (acc + ROUND_HALF) >>> (3 * T_FRAC_BITS);
      if (acc > COORD_MAX) acc = COORD_MAX;
      if (acc < COORD_MIN) acc = COORD_MIN;
      return acc[COORD_BITS-1:0];
   endfunction

   function automatic curve_point_type curve_point(input segment_beat_type s);
      curve_point_type p;
      p.curve_x = bernstein_axis(s.param_t, s.p0_x, s.p1_x, s.p2_x, s.p3_x);
      p.curve_y = bernstein_axis(s.param_t, s.p0_y, s.p1_y, s.p2_y, s.p3_y);
      return p;
   endfunction

   function automatic logic signed [COORD_BITS-1:0] rand_coord();
      case ($urandom_range(9))
         0: return C_MIN;
         1: return C_MAX;
         2: return COORD_BITS'($signed(COORD_BITS'($urandom_range(3))) - 2);
         default: return COORD_BITS'($urandom);
      endcase
   endfunction

   task automatic queue_segment(
      input logic        [T_FRAC_BITS:0]  t,
      input logic signed [COORD_BITS-1:0] x0, y0, x1, y1, x2, y2, x3, y3
   );
      segment_beat_type s;
      s.param_t = t;
      s.p0_x = x0;  s.p0_y = y0;
      s.p1_x = x1;  s.p1_y = y1;
      s.p2_x = x2;  s.p2_y = y2;
      s.p3_x = x3;  s.p3_y = y3;
      segments_pending.push_back(s);
   endtask

   // Idling per phase, keyed on how many beats have been presented.
   always_comb begin
      case (beats_sent / PHASE_LEN)
         0: begin
            idle_pct = 0;
            stall_pct = 0;
         end
         1: begin
            idle_pct = 75;
            stall_pct = 0;
         end
         2: begin
            idle_pct = 0;
            stall_pct = 75;
         end
         3: begin
            idle_pct = 10;
            stall_pct = 10;
         end
         default: begin
            idle_pct = 0;
            stall_pct = 10;
         end
      endcase
   end

   // Driver: advance to the next segment once the current beat is taken, hold otherwise.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (segments_pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
            next_segment = segments_pending.pop_front();
            req_valid   <= 1'b1;
            req_param_t <= next_segment.param_t;
            req_p0_x    <= next_segment.p0_x;
            req_p0_y    <= next_segment.p0_y;
            req_p1_x    <= next_segment.p1_x;
            req_p1_y    <= next_segment.p1_y;
            req_p2_x    <= next_segment.p2_x;
            req_p2_y    <= next_segment.p2_y;
            req_p3_x    <= next_segment.p3_x;
            req_p3_y    <= next_segment.p3_y;
            beats_sent  <= beats_sent + 1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver backpressure.
   always @(negedge clock) begin
      rsp_stall <= !reset && (hold_off || $urandom_range(99) < stall_pct);
   end

   // Long hold-off so the pipeline fills and stalls its input.
   initial begin
      wait (beats_sent >= 4 * PHASE_LEN + 40);
      @(negedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(negedge clock);
      hold_off <= 1'b0;
   end

   // Monitor: check result beats in order, predict each accepted segment.
   always @(posedge clock) begin
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            if (points_due.size() == 0) begin
               $error("result beat with no point due: curve_x=%0d curve_y=%0d",
                      rsp_curve_x, rsp_curve_y);
               mismatches++;
            end else begin
               due_point = points_due.pop_front();
               if (rsp_curve_x !== due_point.curve_x) begin
                  $error("curve_x: expected %0d, got %0d", due_point.curve_x, rsp_curve_x);
                  mismatches++;
               end
               if (rsp_curve_y !== due_point.curve_y) begin
                  $error("curve_y: expected %0d, got %0d", due_point.curve_y, rsp_curve_y);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            points_due.push_back(curve_point({req_param_t, req_p0_x, req_p0_y, req_p1_x,
                                              req_p1_y, req_p2_x, req_p2_y, req_p3_x,
                                              req_p3_y}));
            beats_taken <= beats_taken + 1;
         end
      end
   end

   initial begin
      logic [T_FRAC_BITS:0] t;

      // endpoints give P0 and P3
      queue_segment('0, 100, -200, 300, -400, 500, -600, 700, -800);
      queue_segment(T_ONE_Q, 100, -200, 300, -400, 500, -600, 700, -800);
      // parameter above one saturates to P3
      queue_segment(T_ONE_Q + 1'b1, 11, 22, 33, 44, 55, 66, -77, 88);
      queue_segment(T_TOP_Q, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN);
      // ties at t = 1/2 round toward plus infinity
      queue_segment(T_HALF_Q, 1, -1, 1, -1, 0, 0, 0, 0);
      queue_segment(T_HALF_Q, -3, 3, 0, 0, 0, 0, -1, 1);
      // coordinate extremes
      queue_segment(T_HALF_Q, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
      queue_segment(T_HALF_Q, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
      queue_segment(1, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN);
      queue_segment(T_ONE_Q - 1'b1, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX);
      queue_segment(21845, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN);
      queue_segment(43691, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN);
      queue_segment(1, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN);
      queue_segment(T_ONE_Q - 1'b1, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX);
      queue_segment(T_ONE_Q + 1'b1, 0, 0, 0, 0, 0, 0, C_MIN, C_MAX);
      queue_segment(T_HALF_Q, 0, 0, 0, 0, 0, 0, 0, 0);

      // random segments, edges of t weighted up
      repeat (RANDOM_BEATS) begin
         case ($urandom_range(15))
            0: t = '0;
            1: t = T_ONE_Q;
            2: t = (T_FRAC_BITS+1)'($urandom_range(int'(T_TOP_Q), int'(T_ONE_Q) + 1));
            3: t = (T_FRAC_BITS+1)'($urandom_range(3));
            4: t = T_ONE_Q - (T_FRAC_BITS+1)'($urandom_range(3));
            5: t = T_HALF_Q;
            default: t = (T_FRAC_BITS+1)'($urandom_range(int'(T_ONE_Q)));
         endcase
         queue_segment(t, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                       rand_coord(), rand_coord(), rand_coord(), rand_coord());
      end
      total_beats = segments_pending.size();

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      wait (beats_taken == total_beats && points_due.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
